@@ design/spar_pkg.sv @@
package spar_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ANGLE_W    = 17;
    localparam int STEP_W     = 16;
    localparam int MAG_W      = ANGLE_W + FRAC_BITS;
    localparam int DIFF_W     = MAG_W + 1;
    localparam int DATA_W     = ((ANGLE_W + 7) / 8) * 8;
    localparam int CNT_W      = $clog2(MAG_W + 1);

    localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(92160);
    localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(46080);

    localparam logic signed [DIFF_W-1:0] FULL_FX =
        $signed({{(DIFF_W-ANGLE_W){1'b0}}, FULL_TURN}) <<< FRAC_BITS;
    localparam logic signed [DIFF_W-1:0] HALF_FX =
        $signed({{(DIFF_W-ANGLE_W){1'b0}}, HALF_TURN}) <<< FRAC_BITS;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(50);

    localparam logic FUNC_TARGET = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CORR,
        ST_START
    } ctl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_SIGN
    } div_state_t;

    typedef struct packed {
        logic                     start;
        logic [STEP_W-1:0]        divisor;
        logic signed [DIFF_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIFF_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ design/spar_div.sv @@
module spar_div
    import spar_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    div_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [MAG_W-1:0]         q_reg, q_next;
    logic [STEP_W-1:0]        rem_reg, rem_next;
    logic [STEP_W-1:0]        dvsr_reg, dvsr_next;
    logic                     neg_reg, neg_next;
    logic                     done_reg, done_next;
    logic signed [DIFF_W-1:0] quot_reg, quot_next;

    logic [DIFF_W-1:0]        abs_in;
    logic [STEP_W:0]          trial;
    logic [STEP_W:0]          trial_sub;
    logic [DIFF_W-1:0]        q_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;
        abs_in     = req.dividend[DIFF_W-1] ? DIFF_W'(-req.dividend) : req.dividend;
        // Restoring step: bring down the next dividend bit and try the divisor.
        trial      = {rem_reg, q_reg[MAG_W-1]};
        trial_sub  = trial - {1'b0, dvsr_reg};
        q_ext      = {1'b0, q_reg};
        case (state_reg)
            DIV_IDLE: begin
                if (req.start) begin
                    neg_next   = req.dividend[DIFF_W-1];
                    q_next     = abs_in[MAG_W-1:0];
                    rem_next   = '0;
                    dvsr_next  = req.divisor;
                    cnt_next   = '0;
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (trial >= {1'b0, dvsr_reg}) begin
                    rem_next = trial_sub[STEP_W-1:0];
                    q_next   = {q_reg[MAG_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[STEP_W-1:0];
                    q_next   = {q_reg[MAG_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1)) begin
                    state_next = DIV_SIGN;
                end
            end
            DIV_SIGN: begin
                quot_next  = neg_reg ? $signed(-q_ext) : $signed(q_ext);
                done_next  = 1'b1;
                state_next = DIV_IDLE;
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

@@ design/shortest_path_angle_ramp_top.sv @@
// Target word: the next word is taken after the difference, wrap correction and
// divider start states, the 33-step serial divider and its sign state.
// Tick word: the tick is registered, then its result goes to the output register;
// no word is taken while a tick is pending. A word is accepted only while the output
// register is free. Reset (aresetn, synchronous, active low) clears the angle,
// increment, goal and tick count, leaves the ramp idle and sets step_count to 50.
module shortest_path_angle_ramp_top
    import spar_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [16:0] target_angle, rest zero
    input  logic              s_tuser,   // [0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [16:0] angle, rest zero
    output logic              m_tlast,   // done_res
    output logic              m_tuser,   // [0] error
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [STEP_W-1:0] cfg_data
);

    ctl_state_t               state_reg, state_next;
    logic                     tick_reg, tick_next;
    logic                     wait_reg, wait_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [MAG_W-1:0]         cur_reg, cur_next;
    logic signed [DIFF_W-1:0] inc_reg, inc_next;
    logic [ANGLE_W-1:0]       goal_reg, goal_next;
    logic [STEP_W-1:0]        ticks_reg, ticks_next;
    logic                     moving_reg, moving_next;
    logic [ANGLE_W-1:0]       tgt_reg, tgt_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic                     mv_reg, mv_next;
    logic [ANGLE_W-1:0]       mang_reg, mang_next;
    logic                     mlast_reg, mlast_next;
    logic                     merr_reg, merr_next;

    logic [STEP_W-1:0]        eff_steps;
    logic                     in_acc;
    logic                     out_free;
    logic [ANGLE_W-1:0]       in_tgt;
    logic [STEP_W-1:0]        tick_cnt;
    // One bit above the increment: a step count raised during a glide can leave
    // an increment large enough to carry past the signed range of the angle.
    logic signed [DIFF_W:0]   sum;
    logic signed [DIFF_W:0]   sum_wrap;
    logic [ANGLE_W-1:0]       goal_wrap;
    div_req_t                 dreq;
    div_rsp_t                 drsp;

    spar_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign eff_steps = (step_reg == '0) ? STEP_W'(1) : step_reg;
    assign out_free  = !mv_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !tick_reg && !wait_reg && out_free;
    assign in_acc    = s_tvalid && s_tready;
    assign in_tgt    = s_tdata[ANGLE_W-1:0];
    assign cfg_ready = 1'b1;

    assign dreq.start    = (state_reg == ST_START);
    assign dreq.divisor  = eff_steps;
    assign dreq.dividend = diff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            tick_reg   <= 1'b0;
            wait_reg   <= 1'b0;
            step_reg   <= STEP_RESET;
            cur_reg    <= '0;
            inc_reg    <= '0;
            goal_reg   <= '0;
            ticks_reg  <= '0;
            moving_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            wait_reg   <= wait_next;
            step_reg   <= step_next;
            cur_reg    <= cur_next;
            inc_reg    <= inc_next;
            goal_reg   <= goal_next;
            ticks_reg  <= ticks_next;
            moving_reg <= moving_next;
            mv_reg     <= mv_next;
        end
        tgt_reg   <= tgt_next;
        diff_reg  <= diff_next;
        mang_reg  <= mang_next;
        mlast_reg <= mlast_next;
        merr_reg  <= merr_next;
    end

    always_comb begin
        state_next  = state_reg;
        tick_next   = 1'b0;
        wait_next   = wait_reg;
        step_next   = step_reg;
        cur_next    = cur_reg;
        inc_next    = inc_reg;
        goal_next   = goal_reg;
        ticks_next  = ticks_reg;
        moving_next = moving_reg;
        tgt_next    = tgt_reg;
        diff_next   = diff_reg;
        mv_next     = mv_reg && !m_tready;
        mang_next   = mang_reg;
        mlast_next  = mlast_reg;
        merr_next   = merr_reg;

        tick_cnt  = ticks_reg + 1'b1;
        sum       = $signed({2'b00, cur_reg}) + inc_reg;
        sum_wrap  = sum;
        if (sum < 0) begin
            sum_wrap = sum + FULL_FX;
        end else if (sum >= FULL_FX) begin
            sum_wrap = sum - FULL_FX;
        end
        goal_wrap = (goal_reg >= FULL_TURN) ? goal_reg - FULL_TURN : goal_reg;

        if (cfg_valid) begin
            step_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == FUNC_TARGET) begin
                        if (in_tgt > FULL_TURN) begin
                            mv_next    = 1'b1;
                            mang_next  = cur_reg[MAG_W-1:FRAC_BITS];
                            mlast_next = 1'b1;
                            merr_next  = 1'b1;
                        end else begin
                            tgt_next   = in_tgt;
                            state_next = ST_DIFF;
                        end
                    end else if (moving_reg) begin
                        tick_next = 1'b1;
                    end
                end
                if (tick_reg) begin
                    ticks_next = tick_cnt;
                    mv_next    = 1'b1;
                    merr_next  = 1'b0;
                    // The glide lands exactly on the goal; a wrapped count also ends it.
                    if (tick_cnt >= eff_steps || tick_cnt == '0) begin
                        cur_next    = {goal_wrap, {FRAC_BITS{1'b0}}};
                        moving_next = 1'b0;
                        mang_next   = goal_wrap;
                        mlast_next  = 1'b1;
                    end else begin
                        cur_next   = sum_wrap[MAG_W-1:0];
                        mang_next  = sum_wrap[MAG_W-1:FRAC_BITS];
                        mlast_next = 1'b0;
                    end
                end
                if (wait_reg && drsp.done) begin
                    wait_next   = 1'b0;
                    inc_next    = drsp.quotient;
                    goal_next   = tgt_reg;
                    ticks_next  = '0;
                    moving_next = 1'b1;
                end
            end
            ST_DIFF: begin
                diff_next  = $signed({1'b0, tgt_reg, {FRAC_BITS{1'b0}}})
                           - $signed({1'b0, cur_reg});
                state_next = ST_CORR;
            end
            ST_CORR: begin
                // Take the shorter way round the circle.
                if (diff_reg <= -HALF_FX) begin
                    diff_next = diff_reg + FULL_FX;
                end else if (diff_reg >= HALF_FX) begin
                    diff_next = diff_reg - FULL_FX;
                end
                state_next = ST_START;
            end
            ST_START: begin
                wait_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(DATA_W-ANGLE_W){1'b0}}, mang_reg};
    assign m_tlast  = mlast_reg;
    assign m_tuser  = merr_reg;

endmodule

@@ tb/tb_shortest_path_angle_ramp_top.sv @@
module tb_shortest_path_angle_ramp_top;
    import spar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CYCLE_LIMIT     = 1000000;
    localparam int     SETTLE_CYCLES   = 50;
    localparam int     RANDOM_PHASES   = 9;
    localparam int     WORDS_PER_PHASE = 192;
    localparam int     MAX_TICK_RUN    = 40;
    localparam longint FULL_FX_L       = longint'(FULL_TURN) <<< FRAC_BITS;
    localparam longint HALF_FX_L       = longint'(HALF_TURN) <<< FRAC_BITS;

    typedef struct packed {
        logic               func;
        logic [ANGLE_W-1:0] tgt;
    } glide_word_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               done;
        logic               err;
    } angle_res_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [STEP_W-1:0] cfg_data  = '0;

    // Words waiting to be sent and angles still owed by the block.
    glide_word_t word_q[$];
    angle_res_t  angle_q[$];

    // Shadow copy of the ramp state.
    logic [STEP_W-1:0]  step_reg  = STEP_RESET;
    longint             cur_fx    = 0;
    longint             glide_inc = 0;
    logic [ANGLE_W-1:0] goal      = '0;
    logic [STEP_W-1:0]  tick_cnt  = '0;
    bit                 gliding   = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_cnt      = 0;
    int in_acc        = 0;
    int target_cnt    = 0;
    int tick_word_cnt = 0;
    int res_cnt       = 0;
    int reject_cnt    = 0;
    int done_cnt      = 0;
    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int step_settings = 0;

    shortest_path_angle_ramp_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Advances the shadow ramp by one word; returns 1 when the word yields an angle.
    function automatic bit predict_glide(input logic func, input logic [ANGLE_W-1:0] tgt,
                                         output angle_res_t res);
        longint             diff;
        longint             nxt;
        longint             eff;
        logic [ANGLE_W-1:0] g;
        eff = (step_reg == '0) ? 1 : longint'(step_reg);
        res = '0;
        if (func == FUNC_TARGET) begin
            if (tgt > FULL_TURN) begin
                res.angle = ANGLE_W'(cur_fx >> FRAC_BITS);
                res.done  = 1'b1;
                res.err   = 1'b1;
                return 1'b1;
            end
            diff = (longint'(tgt) <<< FRAC_BITS) - cur_fx;
            if (diff <= -HALF_FX_L) begin
                diff += FULL_FX_L;
            end else if (diff >= HALF_FX_L) begin
                diff -= FULL_FX_L;
            end
            glide_inc = diff / eff;
            goal      = tgt;
            tick_cnt  = '0;
            gliding   = 1'b1;
            return 1'b0;
        end
        if (!gliding) begin
            return 1'b0;
        end
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= eff || tick_cnt == '0) begin
            g         = (goal >= FULL_TURN) ? goal - FULL_TURN : goal;
            cur_fx    = longint'(g) <<< FRAC_BITS;
            gliding   = 1'b0;
            res.angle = g;
            res.done  = 1'b1;
            return 1'b1;
        end
        nxt = cur_fx + glide_inc;
        if (nxt < 0) begin
            nxt += FULL_FX_L;
        end else if (nxt >= FULL_FX_L) begin
            nxt -= FULL_FX_L;
        end
        cur_fx    = nxt;
        res.angle = ANGLE_W'(cur_fx >> FRAC_BITS);
        return 1'b1;
    endfunction

    // Driver: holds a word until it is taken, otherwise sends the next one or idles.
    always @(negedge aclk) begin
        glide_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && in_acc != sent_cnt) begin
            s_tvalid <= 1'b1;
        end else if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            w = word_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= DATA_W'(w.tgt);
            s_tuser  <= w.func;
            sent_cnt <= sent_cnt + 1;
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: predicts on every accepted word and checks every accepted angle.
    always @(posedge aclk) begin
        angle_res_t r;
        angle_res_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_acc <= in_acc + 1;
                if (s_tuser == FUNC_TARGET) begin
                    target_cnt++;
                end else begin
                    tick_word_cnt++;
                end
                if (predict_glide(s_tuser, s_tdata[ANGLE_W-1:0], r)) begin
                    angle_q.push_back(r);
                end
            end
            if (m_tvalid && m_tready) begin
                res_cnt++;
                if (angle_q.size() == 0) begin
                    $error("unexpected result word: angle %0d done %0b error %0b",
                           m_tdata, m_tlast, m_tuser);
                    err_cnt++;
                end else begin
                    want = angle_q.pop_front();
                    if (want.err) begin
                        reject_cnt++;
                    end else if (want.done) begin
                        done_cnt++;
                    end
                    if (m_tdata !== DATA_W'(want.angle)) begin
                        $error("angle: expected %0d, got %0d", want.angle, m_tdata);
                        err_cnt++;
                    end
                    if (m_tlast !== want.done) begin
                        $error("done_res: expected %0b, got %0b", want.done, m_tlast);
                        err_cnt++;
                    end
                    if (m_tuser !== want.err) begin
                        $error("error: expected %0b, got %0b", want.err, m_tuser);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d angles outstanding", cycle_cnt,
                     angle_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_word(input logic func, input logic [ANGLE_W-1:0] tgt);
        glide_word_t w;
        w.func = func;
        w.tgt  = tgt;
        word_q.push_back(w);
    endtask

    // Waits until every word is taken and every angle has arrived, then lets a
    // target word that produces no result finish its division.
    task automatic drain();
        while (word_q.size() != 0 || s_tvalid || angle_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_steps(input logic [STEP_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        step_reg = v;
        step_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole glides (a target and about as many ticks as it needs) with
    // random content, mixed with rejected targets and stray ticks.
    task automatic queue_random(input int quota);
        int                 n;
        int                 k;
        int                 kind;
        int                 eff;
        logic [ANGLE_W-1:0] t;
        eff = (step_reg == '0) ? 1 : int'(step_reg);
        n   = 0;
        while (n < quota) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                case ($urandom_range(0, 7))
                    0: t = '0;
                    1: t = FULL_TURN;
                    2: t = FULL_TURN - 1'b1;
                    3: t = HALF_TURN;
                    default: t = ANGLE_W'($urandom_range(0, FULL_TURN));
                endcase
                push_word(FUNC_TARGET, t);
                if (eff > MAX_TICK_RUN) begin
                    k = $urandom_range(1, MAX_TICK_RUN);
                end else if ($urandom_range(0, 4) == 0) begin
                    k = $urandom_range(0, eff - 1);
                end else begin
                    k = eff + $urandom_range(0, 2);
                end
                repeat (k) push_word(FUNC_TICK, ANGLE_W'($urandom));
                n += k + 1;
            end else if (kind == 7) begin
                if ($urandom_range(0, 3) == 0) begin
                    t = '1;
                end else begin
                    t = ANGLE_W'($urandom_range(FULL_TURN + 1, (1 << ANGLE_W) - 1));
                end
                push_word(FUNC_TARGET, t);
                n++;
            end else begin
                push_word(FUNC_TICK, ANGLE_W'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        logic [STEP_W-1:0] phase_steps [RANDOM_PHASES];
        phase_steps = '{16'd3, 16'd1, 16'd65535, 16'd12, 16'd0, 16'd2, 16'd37, 16'd500,
                        16'd0};
        phase_steps[RANDOM_PHASES-1] = STEP_W'($urandom_range(1, 64));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 79;

        // Reset step count of 50: idle tick, rejected targets, a half-turn
        // target that wraps below zero, and a rejection in the middle of a glide.
        push_word(FUNC_TICK, '0);
        push_word(FUNC_TARGET, FULL_TURN + 1'b1);
        push_word(FUNC_TARGET, '1);
        push_word(FUNC_TARGET, HALF_TURN);
        repeat (3) push_word(FUNC_TICK, '1);
        push_word(FUNC_TARGET, ANGLE_W'(100000));
        push_word(FUNC_TICK, '0);
        drain();

        // Lowering the step count under a running glide ends it on the next tick.
        write_steps(16'd1);
        push_word(FUNC_TICK, '0);
        push_word(FUNC_TARGET, FULL_TURN);
        push_word(FUNC_TICK, '0);
        push_word(FUNC_TARGET, FULL_TURN - 1'b1);
        push_word(FUNC_TICK, '0);
        push_word(FUNC_TICK, '0);
        drain();

        // A step count of zero behaves like one.
        write_steps(16'd0);
        push_word(FUNC_TARGET, ANGLE_W'(1));
        push_word(FUNC_TICK, '0);
        drain();

        write_steps(16'd65535);
        push_word(FUNC_TARGET, HALF_TURN + 1'b1);
        repeat (2) push_word(FUNC_TICK, '0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 79;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_steps(phase_steps[p]);
            queue_random(WORDS_PER_PHASE);
            drain();
        end

        $display("sent %0d target and %0d tick words under %0d step-count settings",
                 target_cnt, tick_word_cnt, step_settings);
        $display("checked %0d angles: %0d glide ends, %0d rejected targets",
                 res_cnt, done_cnt, reject_cnt);
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/spar_pkg.sv
design/spar_div.sv
design/shortest_path_angle_ramp_top.sv
tb/tb_shortest_path_angle_ramp_top.sv
